>>> design/tilt_to_pointer_delta_macros.svh
// Assertion helpers used by the checker file.
`ifndef TILT_TO_POINTER_DELTA_MACROS_SVH
`define TILT_TO_POINTER_DELTA_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define TTPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define TTPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ttpd_pkg.sv
package ttpd_pkg;

    typedef struct packed {
        logic               sample_valid;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
    } t_out_item;

    typedef struct packed {
        logic [14:0] deadzone_level;
        logic [14:0] full_scale_level;
        logic [15:0] smoothing_weight;
        logic [6:0]  max_step;
    } t_cfg;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SQX,
        CMD_SQY,
        CMD_SQRT_STEP,
        CMD_USAT,
        CMD_DIVU_INIT,
        CMD_DIV_STEP,
        CMD_UQ,
        CMD_IDX,
        CMD_ROM,
        CMD_SPEED,
        CMD_PROD,
        CMD_DIVR_INIT,
        CMD_RAW_STORE,
        CMD_FLT_A,
        CMD_FLT_B,
        CMD_FLT_C
    } t_cmd;

    typedef struct packed {
        t_cmd op;
        logic axis_y;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_ok;
        logic dz_in;
        logic sat;
    } t_dp_sts;

    localparam logic [1:0] REG_DEADZONE   = 2'd0;
    localparam logic [1:0] REG_FULL_SCALE = 2'd1;
    localparam logic [1:0] REG_SMOOTHING  = 2'd2;
    localparam logic [1:0] REG_MAX_STEP   = 2'd3;

    localparam int CNT_W      = 5;
    localparam int SQRT_STEPS = 16;
    localparam int DIVU_STEPS = 16;
    localparam int DIVR_STEPS = 23;

    function automatic longint unsigned ttpd_isqrt(input longint unsigned v);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        x = v;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 with 30 fraction bits, v >= 1
    function automatic longint unsigned ttpd_log2(input int unsigned v);
        int unsigned     k;
        longint unsigned m;
        longint unsigned frac;
        k = 0;
        for (int b = 0; b < 31; b++) begin
            if ((v >> (b + 1)) != 0) k = b + 1;
        end
        m    = 64'(v) << (31 - k);
        frac = 64'd0;
        for (int j = 0; j < 30; j++) begin
            m = (m * m) >> 31;
            if ((m >> 32) != 64'd0) begin
                m    = m >> 1;
                frac = frac | (64'd1 << (29 - j));
            end
        end
        return (64'(k) << 30) | frac;
    endfunction

    // (i/top)^1.7 in Q1.16, evaluated at elaboration
    function automatic logic [16:0] ttpd_curve_entry(input int unsigned i,
                                                     input int unsigned top);
        longint unsigned rh [31];
        longint unsigned d;
        longint unsigned e;
        longint unsigned n;
        longint unsigned f;
        longint unsigned prod;
        if (i == 0) return 17'd0;
        rh[0] = 64'd1 << 32;
        rh[1] = ttpd_isqrt(64'd1 << 63);
        for (int k = 2; k <= 30; k++) rh[k] = ttpd_isqrt(rh[k-1] << 32);
        d    = ttpd_log2(top) - ttpd_log2(i);
        e    = (d * 64'd17) / 64'd10;
        n    = e >> 30;
        f    = e & ((64'd1 << 30) - 64'd1);
        prod = 64'd1 << 32;
        for (int k = 1; k <= 30; k++) begin
            if (((f >> (30 - k)) & 64'd1) != 64'd0) prod = (prod * rh[k]) >> 32;
        end
        if (n >= 64'd40) return 17'd0;
        return 17'(((prod >> n) + 64'd32768) >> 16);
    endfunction

endpackage

>>> design/ttpd_ctrl.sv
module ttpd_ctrl import ttpd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_load,
    output t_dp_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRT, S_CHK, S_DIVU, S_UQ, S_IDX, S_ROM,
        S_SPEED, S_PROD, S_DIVR_INIT, S_DIVR, S_RAW, S_FLT_A, S_FLT_B,
        S_FLT_C, S_OUT
    } t_state;

    t_state           r_state, n_state;
    logic             r_axis, n_axis;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_cmd.op   = CMD_NONE;
        o_cmd.axis_y = r_axis;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_state  = S_SQX;
                end
            end
            S_SQX: begin
                if (!i_sts.sample_ok) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.op = CMD_SQX;
                    n_state  = S_SQY;
                end
            end
            S_SQY: begin
                o_cmd.op = CMD_SQY;
                n_cnt    = CNT_W'(SQRT_STEPS - 1);
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = CMD_SQRT_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_CHK;
            end
            S_CHK: begin
                n_axis = 1'b0;
                priority if (i_sts.dz_in) begin
                    n_state = S_FLT_A;
                end else if (i_sts.sat) begin
                    o_cmd.op = CMD_USAT;
                    n_state  = S_IDX;
                end else begin
                    o_cmd.op = CMD_DIVU_INIT;
                    n_cnt    = CNT_W'(DIVU_STEPS - 1);
                    n_state  = S_DIVU;
                end
            end
            S_DIVU: begin
                o_cmd.op = CMD_DIV_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_UQ;
            end
            S_UQ: begin
                o_cmd.op = CMD_UQ;
                n_state  = S_IDX;
            end
            S_IDX: begin
                o_cmd.op = CMD_IDX;
                n_state  = S_ROM;
            end
            S_ROM: begin
                o_cmd.op = CMD_ROM;
                n_state  = S_SPEED;
            end
            S_SPEED: begin
                o_cmd.op = CMD_SPEED;
                n_axis   = 1'b0;
                n_state  = S_PROD;
            end
            S_PROD: begin
                o_cmd.op = CMD_PROD;
                n_state  = S_DIVR_INIT;
            end
            S_DIVR_INIT: begin
                o_cmd.op = CMD_DIVR_INIT;
                n_cnt    = CNT_W'(DIVR_STEPS - 1);
                n_state  = S_DIVR;
            end
            S_DIVR: begin
                o_cmd.op = CMD_DIV_STEP;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_RAW;
            end
            S_RAW: begin
                o_cmd.op = CMD_RAW_STORE;
                n_axis   = !r_axis;
                n_state  = r_axis ? S_FLT_A : S_PROD;
            end
            S_FLT_A: begin
                o_cmd.op = CMD_FLT_A;
                n_state  = S_FLT_B;
            end
            S_FLT_B: begin
                o_cmd.op = CMD_FLT_B;
                n_state  = S_FLT_C;
            end
            S_FLT_C: begin
                o_cmd.op = CMD_FLT_C;
                n_axis   = !r_axis;
                n_state  = r_axis ? S_OUT : S_FLT_A;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> design/ttpd_dp.sv
module ttpd_dp import ttpd_pkg::*; #(
    parameter int CURVE_ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_in,
    input  t_cfg      i_cfg,
    output t_dp_sts   o_sts,
    output t_out_item o_result
);

    localparam int IW = $clog2(CURVE_ENTRIES);
    localparam int PW = 17 + IW + 1;

    logic [16:0] w_rom [CURVE_ENTRIES];

    for (genvar g = 0; g < CURVE_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = ttpd_curve_entry(g, CURVE_ENTRIES - 1);
    end

    logic               r_ok;
    logic signed [16:0] r_sx, r_sy;
    logic [31:0]        r_rad;
    logic [19:0]        r_srem;
    logic [15:0]        r_mag;
    logic [15:0]        r_drem;
    logic [22:0]        r_dnum;
    logic [15:0]        r_dden;
    logic [22:0]        r_q;
    logic [16:0]        r_u;
    logic [IW-1:0]      r_idx;
    logic [16:0]        r_curve;
    logic [22:0]        r_speed;
    logic [38:0]        r_prod;
    logic signed [15:0] r_rawx, r_rawy;
    logic signed [34:0] r_t;
    logic signed [15:0] r_smx, r_smy;
    logic signed [7:0]  r_move_x, r_move_y;

    // stick magnitudes
    logic signed [16:0] w_nsx, w_nsy;
    logic [15:0]        w_ax, w_ay, w_a;
    assign w_nsx = 17'sd0 - {i_in.accel_x[15], i_in.accel_x};
    assign w_nsy = 17'sd0 - {i_in.accel_y[15], i_in.accel_y};
    assign w_ax  = r_sx[16] ? 16'(-r_sx) : r_sx[15:0];
    assign w_ay  = r_sy[16] ? 16'(-r_sy) : r_sy[15:0];
    assign w_a   = i_cmd.axis_y ? w_ay : w_ax;

    // square root step, two radicand bits per cycle
    logic [19:0] w_ssh, w_trial;
    logic        w_sge;
    assign w_ssh   = {r_srem[17:0], r_rad[31:30]};
    assign w_trial = {2'b00, r_mag, 2'b01};
    assign w_sge   = w_ssh >= w_trial;

    // restoring divider step
    logic [16:0] w_dsh;
    logic        w_dge;
    assign w_dsh = {r_drem, r_dnum[22]};
    assign w_dge = w_dsh >= {1'b0, r_dden};

    logic [PW-1:0]   w_scaled;
    logic [IW+1:0]   w_idx_full;
    logic [IW-1:0]   w_idx;
    assign w_scaled   = PW'(r_u) * PW'(CURVE_ENTRIES - 1) + PW'(32768);
    assign w_idx_full = w_scaled[PW-1:16];
    assign w_idx      = (w_idx_full > (IW+2)'(CURVE_ENTRIES - 1)) ?
                        IW'(CURVE_ENTRIES - 1) : w_idx_full[IW-1:0];

    logic [23:0] w_speed_full;
    assign w_speed_full = 24'(r_curve) * 24'(i_cfg.max_step);

    logic [14:0]        w_rmag;
    logic signed [15:0] w_raw_val;
    logic               w_neg;
    assign w_rmag    = r_q[22:8];
    assign w_neg     = i_cmd.axis_y ? r_sy[16] : r_sx[16];
    assign w_raw_val = w_neg ? -$signed({1'b0, w_rmag}) : $signed({1'b0, w_rmag});

    // exponential filter operands
    logic signed [15:0] w_raw, w_old;
    logic signed [34:0] w_op_w, w_op_iw, w_op_raw, w_op_old;
    logic [16:0]        w_iw;
    assign w_raw    = i_cmd.axis_y ? r_rawy : r_rawx;
    assign w_old    = i_cmd.axis_y ? r_smy : r_smx;
    assign w_iw     = 17'h10000 - {1'b0, i_cfg.smoothing_weight};
    assign w_op_w   = {19'd0, i_cfg.smoothing_weight};
    assign w_op_iw  = {18'd0, w_iw};
    assign w_op_raw = {{19{w_raw[15]}}, w_raw};
    assign w_op_old = {{19{w_old[15]}}, w_old};

    logic signed [34:0] w_tadj;
    logic signed [15:0] w_nv;
    logic signed [16:0] w_cadj;
    logic signed [7:0]  w_c, w_lim, w_out;
    assign w_tadj = r_t[34] ? (r_t + 35'sd65535) : r_t;
    assign w_nv   = w_tadj[31:16];
    assign w_cadj = w_nv[15] ? ({w_nv[15], w_nv} + 17'sd255) : {w_nv[15], w_nv};
    assign w_c    = w_cadj[15:8];
    assign w_lim  = $signed({1'b0, i_cfg.max_step});

    always_comb begin
        priority if (w_c > w_lim) w_out = w_lim;
        else if (w_c < -w_lim)    w_out = -w_lim;
        else                      w_out = w_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smx <= '0;
            r_smy <= '0;
        end else if (i_cmd.op == CMD_FLT_C) begin
            if (i_cmd.axis_y) r_smy <= w_nv;
            else              r_smx <= w_nv;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_ok     <= i_in.sample_valid;
                r_sx     <= w_nsx;
                r_sy     <= w_nsy;
                r_rawx   <= '0;
                r_rawy   <= '0;
                r_move_x <= '0;
                r_move_y <= '0;
            end
            CMD_SQX: r_rad <= 32'(w_ax) * 32'(w_ax);
            CMD_SQY: begin
                r_rad  <= r_rad + 32'(w_ay) * 32'(w_ay);
                r_srem <= '0;
                r_mag  <= '0;
            end
            CMD_SQRT_STEP: begin
                r_rad  <= {r_rad[29:0], 2'b00};
                r_srem <= w_sge ? (w_ssh - w_trial) : w_ssh;
                r_mag  <= {r_mag[14:0], w_sge};
            end
            CMD_USAT: r_u <= 17'h10000;
            CMD_DIVU_INIT: begin
                r_drem <= r_mag - {1'b0, i_cfg.deadzone_level};
                r_dnum <= '0;
                r_dden <= {1'b0, i_cfg.full_scale_level - i_cfg.deadzone_level};
                r_q    <= '0;
            end
            CMD_DIV_STEP: begin
                r_drem <= w_dge ? 16'(w_dsh - {1'b0, r_dden}) : w_dsh[15:0];
                r_dnum <= {r_dnum[21:0], 1'b0};
                r_q    <= {r_q[21:0], w_dge};
            end
            CMD_UQ:    r_u     <= {1'b0, r_q[15:0]};
            CMD_IDX:   r_idx   <= w_idx;
            CMD_ROM:   r_curve <= w_rom[r_idx];
            CMD_SPEED: r_speed <= w_speed_full[22:0];
            CMD_PROD:  r_prod  <= 39'(w_a) * 39'(r_speed);
            CMD_DIVR_INIT: begin
                r_drem <= r_prod[38:23];
                r_dnum <= r_prod[22:0];
                r_dden <= r_mag;
                r_q    <= '0;
            end
            CMD_RAW_STORE: begin
                if (i_cmd.axis_y) r_rawy <= w_raw_val;
                else              r_rawx <= w_raw_val;
            end
            CMD_FLT_A: r_t <= w_op_w * w_op_raw;
            CMD_FLT_B: r_t <= r_t + w_op_iw * w_op_old;
            CMD_FLT_C: begin
                if (i_cmd.axis_y) r_move_y <= w_out;
                else              r_move_x <= w_out;
            end
            CMD_NONE: ;
            default: ;
        endcase
    end

    assign o_sts.sample_ok = r_ok;
    assign o_sts.dz_in     = r_mag <= {1'b0, i_cfg.deadzone_level};
    assign o_sts.sat       = (i_cfg.full_scale_level <= i_cfg.deadzone_level) ||
                             (r_mag >= {1'b0, i_cfg.full_scale_level});
    assign o_result.move_x = r_move_x;
    assign o_result.move_y = r_move_y;

endmodule

>>> design/tilt_to_pointer_delta.sv
// Tilt to pointer delta: one request carries an accelerometer sample, one
// result carries the pointer movement for it. A request is taken only while
// the block is idle. A valid sample outside the deadzone passes through the
// bit-serial square root and the shared one-bit-per-cycle divider, run once
// for the normalized speed (skipped when the speed saturates) and once per
// axis for the direction split. Inside the deadzone no division runs, and an
// invalid sample skips the square root too. The finished result sits in an
// output register, so the next request is taken while it waits. Registers: 0
// deadzone, 1 full scale, 2 smoothing weight, 3 max step; write them only
// while idle.
module tilt_to_pointer_delta import ttpd_pkg::*; #(
    parameter int CURVE_ENTRIES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_item r_out;
    t_dp_cmd   w_cmd;
    t_dp_sts   w_sts;
    t_out_item w_result;
    logic      w_out_load;
    logic      w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadzone_level   <= 15'd410;
            r_cfg.full_scale_level <= 15'd3072;
            r_cfg.smoothing_weight <= 16'd18350;
            r_cfg.max_step         <= 7'd28;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEADZONE:   r_cfg.deadzone_level   <= i_cfg_data[14:0];
                REG_FULL_SCALE: r_cfg.full_scale_level <= i_cfg_data[14:0];
                REG_SMOOTHING:  r_cfg.smoothing_weight <= i_cfg_data;
                REG_MAX_STEP:   r_cfg.max_step         <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) r_out <= w_result;
    end

    ttpd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_out_load (w_out_load),
        .o_cmd      (w_cmd)
    );

    ttpd_dp #(.CURVE_ENTRIES(CURVE_ENTRIES)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> design/ttpd_chk.sv
`include "tilt_to_pointer_delta_macros.svh"

module ttpd_chk import ttpd_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    // one request at a time
    `TTPD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready, "request taken while busy")

    `TTPD_ASSERT_NOW(a_move_range, i_clk, i_rst_n, o_out_valid,
        o_out.move_x != 8'sh80 && o_out.move_y != 8'sh80, "movement out of range")

    `TTPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out), "stalled result changed")

    // results are produced only while a request is in flight
    `TTPD_ASSERT_NOW(a_out_from_busy, i_clk, i_rst_n, $rose(o_out_valid),
        $past(!o_in_ready), "result without a request in flight")

endmodule

bind tilt_to_pointer_delta ttpd_chk u_ttpd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

>>> bench/tb_top.sv
module tb_top;
    import ttpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CURVE_N = 256;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    tilt_to_pointer_delta #(.CURVE_ENTRIES(CURVE_N)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [16:0]        power_curve [CURVE_N];
    logic [14:0]        dz_lvl;
    logic [14:0]        fs_lvl;
    logic [15:0]        ema_weight;
    logic [6:0]         step_lim;
    logic signed [15:0] ema_x;
    logic signed [15:0] ema_y;

    t_out_item pending_moves [$];
    int        fail_cnt;
    int        req_cnt;
    int        move_cnt;
    int        tx_idle_pct;
    int        rx_idle_pct;
    int        rx_hold_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("tilt_to_pointer_delta: mismatch");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned acc;
        longint unsigned root;
        longint unsigned bitv;
        acc  = v;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > acc) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (acc >= root + bitv) begin
                acc  = acc - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // log2 in Q.30 by repeated squaring of the mantissa
    function automatic longint unsigned log2_q30(input int unsigned v);
        int unsigned     msb;
        longint unsigned mant;
        longint unsigned frac;
        msb = 0;
        while (msb < 31 && (v >> (msb + 1)) != 0) msb++;
        mant = longint'(v) << (31 - msb);
        frac = 0;
        for (int j = 0; j < 30; j++) begin
            mant = (mant * mant) >> 31;
            if ((mant >> 32) != 0) begin
                mant = mant >> 1;
                frac = frac | (64'd1 << (29 - j));
            end
        end
        return (longint'(msb) << 30) | frac;
    endfunction

    task automatic build_power_curve();
        longint unsigned half_roots [31];
        longint unsigned log_top;
        longint unsigned expo;
        longint unsigned whole;
        longint unsigned prod;
        half_roots[0] = 64'd1 << 32;
        half_roots[1] = int_sqrt(64'd1 << 63);
        for (int k = 2; k <= 30; k++) half_roots[k] = int_sqrt(half_roots[k-1] << 32);
        log_top = log2_q30(CURVE_N - 1);
        power_curve[0] = '0;
        for (int i = 1; i < CURVE_N; i++) begin
            expo  = ((log_top - log2_q30(i)) * 64'd17) / 64'd10;
            whole = expo >> 30;
            prod  = 64'd1 << 32;
            for (int k = 1; k <= 30; k++)
                if ((expo >> (30 - k)) & 64'd1) prod = (prod * half_roots[k]) >> 32;
            power_curve[i] = (whole >= 40) ? 17'd0 : 17'(((prod >> whole) + 64'd32768) >> 16);
        end
    endtask

    function automatic int split_axis(input int comp, input longint unsigned speed,
                                      input longint unsigned mag);
        longint unsigned a;
        int r;
        a = (comp < 0) ? longint'(-comp) : longint'(comp);
        r = int'(((a * speed) / mag) >> 8);
        return (comp < 0) ? -r : r;
    endfunction

    function automatic logic [7:0] ema_step(ref logic signed [15:0] st, input int raw);
        longint w;
        longint acc;
        longint nv;
        int cnt;
        w   = longint'(ema_weight);
        acc = w * raw + (65536 - w) * longint'(st);
        nv  = acc / 65536;
        st  = nv[15:0];
        cnt = int'(nv) / 256;
        if (cnt > int'(step_lim)) cnt = int'(step_lim);
        if (cnt < -int'(step_lim)) cnt = -int'(step_lim);
        return cnt[7:0];
    endfunction

    function automatic t_out_item predict_move(input t_in_item it);
        t_out_item       res;
        int              sx;
        int              sy;
        int              rx;
        int              ry;
        longint unsigned mag;
        longint unsigned norm;
        longint unsigned idx;
        longint unsigned speed;
        res = '0;
        if (!it.sample_valid) return res;
        sx  = -int'(it.accel_x);
        sy  = -int'(it.accel_y);
        mag = int_sqrt(longint'(sx) * sx + longint'(sy) * sy);
        rx  = 0;
        ry  = 0;
        if (mag > dz_lvl) begin
            if (fs_lvl <= dz_lvl) begin
                norm = 65536;
            end else begin
                norm = ((mag - dz_lvl) << 16) / longint'(fs_lvl - dz_lvl);
                if (norm > 65536) norm = 65536;
            end
            idx = (norm * (CURVE_N - 1) + 32768) >> 16;
            if (idx > CURVE_N - 1) idx = CURVE_N - 1;
            speed = longint'(power_curve[idx]) * step_lim;
            rx = split_axis(sx, speed, mag);
            ry = split_axis(sy, speed, mag);
        end
        res.move_x = ema_step(ema_x, rx);
        res.move_y = ema_step(ema_y, ry);
        return res;
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            move_cnt++;
            if (pending_moves.size() == 0) begin
                $display("%0t: unexpected result %0d,%0d", $time, o_out.move_x, o_out.move_y);
                fail_cnt++;
            end else begin
                if (o_out.move_x !== pending_moves[0].move_x) begin
                    $display("%0t: move_x expected %0d actual %0d", $time,
                             pending_moves[0].move_x, o_out.move_x);
                    fail_cnt++;
                end
                if (o_out.move_y !== pending_moves[0].move_y) begin
                    $display("%0t: move_y expected %0d actual %0d", $time,
                             pending_moves[0].move_y, o_out.move_y);
                    fail_cnt++;
                end
                void'(pending_moves.pop_front());
            end
        end
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_sample(input t_in_item it);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        pending_moves.push_back(predict_move(it));
        req_cnt++;
    endtask

    task automatic send_tilt(input logic vld, input int x, input int y);
        t_in_item it;
        it.sample_valid = vld;
        it.accel_x      = x[15:0];
        it.accel_y      = y[15:0];
        send_sample(it);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_moves.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_DEADZONE:   dz_lvl     = data[14:0];
            REG_FULL_SCALE: fs_lvl     = data[14:0];
            REG_SMOOTHING:  ema_weight = data;
            REG_MAX_STEP:   step_lim   = data[6:0];
        endcase
    endtask

    task automatic set_config(input int dz, input int fs, input int w, input int ms);
        write_reg(REG_DEADZONE, dz[15:0]);
        write_reg(REG_FULL_SCALE, fs[15:0]);
        write_reg(REG_SMOOTHING, w[15:0]);
        write_reg(REG_MAX_STEP, ms[15:0]);
        i_cfg_we <= 1'b0;
    endtask

    // mostly tilts near the deadzone and full-scale range, some full width, some invalid
    task automatic send_random_tilt();
        int mode;
        int span;
        mode = $urandom_range(9);
        if (mode == 0) begin
            send_tilt(1'b0, $urandom, $urandom);
        end else begin
            span = (mode < 4) ? 32767 : (mode < 7) ? 4096 : 1024;
            send_tilt(1'b1, $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
            if (mode == 9) send_tilt(1'b1, $urandom, $urandom);
        end
    endtask

    task automatic test_directed();
        send_tilt(1'b0, 16'h7fff, -32768);
        send_tilt(1'b1, 0, 0);
        send_tilt(1'b1, -32768, -32768);
        send_tilt(1'b1, -32768, -32768);
        send_tilt(1'b1, 32767, 32767);
        send_tilt(1'b1, 32767, 0);
        send_tilt(1'b1, 0, -32768);
        send_tilt(1'b1, 410, 0);
        send_tilt(1'b1, 0, 411);
        send_tilt(1'b1, 200, -200);
        send_tilt(1'b1, -3072, 0);
        send_tilt(1'b1, 2000, 2000);
        send_tilt(1'b0, 1, 1);
        send_tilt(1'b1, -1, 1);
        send_tilt(1'b1, 1500, -2500);
        send_tilt(1'b1, 0, 0);
        send_tilt(1'b1, 0, 0);
        wait_drain();
    endtask

    task automatic test_config_sweep();
        int settings [7][4] = '{
            '{0,     1,     65535, 127},
            '{32767, 32767, 0,     1},
            '{3000,  2000,  40000, 64},
            '{0,     32767, 1,     127},
            '{100,   100,   30000, 0},
            '{20000, 32767, 65535, 90},
            '{410,   3072,  18350, 28}
        };
        for (int p = 0; p < 7; p++) begin
            set_config(settings[p][0], settings[p][1], settings[p][2], settings[p][3]);
            send_tilt(1'b1, -32768, 32767);
            repeat (35) send_random_tilt();
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        rx_hold_left = 500;
        repeat (10) send_random_tilt();
        wait_drain();
        repeat (10) send_random_tilt();
        wait_drain();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        set_config($urandom_range(1500), $urandom_range(6000, 1), $urandom_range(65535),
                   $urandom_range(127, 1));
        repeat (count) send_random_tilt();
        wait_drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_DEADZONE;
        i_cfg_data   = '0;
        fail_cnt     = 0;
        req_cnt      = 0;
        move_cnt     = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 0;
        dz_lvl       = 15'd410;
        fs_lvl       = 15'd3072;
        ema_weight   = 16'd18350;
        step_lim     = 7'd28;
        ema_x        = '0;
        ema_y        = '0;
        build_power_curve();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random(27, 53, 100);
        test_random(27, 53, 100);
        test_random(53, 27, 100);
        test_random(53, 27, 100);
        test_random(0, 0, 120);
        test_random(0, 0, 120);

        $display("%0d tilt samples sent, %0d pointer moves checked over 14 register settings",
                 req_cnt, move_cnt);
        $display("covered deadzone edges, saturation, zero step, stalls and filter decay");
        if (fail_cnt == 0) begin
            $display("tilt_to_pointer_delta: match");
        end else begin
            $display("tilt_to_pointer_delta: mismatch");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/ttpd_pkg.sv
design/ttpd_ctrl.sv
design/ttpd_dp.sv
design/tilt_to_pointer_delta.sv
design/ttpd_chk.sv
bench/tb_top.sv
